>>> hdl/ufef_pkg.sv
// shared types and constants for the union-find edge filter
package ufef_pkg;

  localparam int NODE_W = 12;
  localparam int CFG_W  = 13;
  localparam logic [CFG_W-1:0] NODE_COUNT_RESET = 13'd4096;

  typedef struct packed {
    logic [NODE_W-1:0] first_node;
    logic [NODE_W-1:0] second_node;
  } in_t;

  typedef struct packed {
    logic              joined;
    logic              index_error;
    logic [NODE_W-1:0] edge_first;
    logic [NODE_W-1:0] edge_second;
  } out_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_FIND_ISSUE,
    S_FIND,
    S_COMP_ISSUE,
    S_COMP,
    S_LINK,
    S_DONE
  } state_t;

endpackage

>>> hdl/union_find_edge_filter.sv
// union-find edge filter top level: root search, path compression and linking
//
// Takes one edge (first_node, second_node) per input transfer and returns one
// result per edge on the output channel: joined, index_error and both nodes.
// An edge whose endpoints lie in different sets links the first root under the
// second and reports joined; an edge inside one set is rejected. Every node on
// a walked path is rewritten to point straight at its root.
// Input is taken only while the sequencer is idle. An edge with an endpoint at
// or beyond min(node_count, MAX_NODES) leaves the table alone. Otherwise one
// parent memory read port chases pointers one link per cycle, first to find the
// root and then again to rewrite the path.
// After reset a sweep sets every entry to its own index; no input is taken
// during it, configuration writes are taken at any time.
// A finished result waits in the output register while the next edge is taken;
// if the receiver still stalls when the next result is ready, the sequencer
// holds until the output register frees up.
module union_find_edge_filter #(
  parameter int MAX_NODES = 4096
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  ufef_pkg::in_t                  in_item,
  output logic                           out_valid,
  input  logic                           out_ready,
  output ufef_pkg::out_t                 out_item,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [ufef_pkg::CFG_W-1:0]     cfg_data
);

  localparam int IDX_W = $clog2(MAX_NODES);
  localparam int CMP_W = 17;
  localparam logic [CMP_W-1:0] MAX_CMP = CMP_W'(MAX_NODES);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_NODES - 1);

  ufef_pkg::state_t state, state_next;

  logic [ufef_pkg::CFG_W-1:0] node_count;
  ufef_pkg::in_t              item, item_next;
  logic                       err, err_next;
  logic                       phase, phase_next;
  logic [IDX_W-1:0]           cur, cur_next;
  logic [IDX_W-1:0]           root, root_next;
  logic [IDX_W-1:0]           root_a, root_a_next;
  logic [IDX_W-1:0]           clr, clr_next;
  ufef_pkg::out_t             out_next;
  logic                       out_load;

  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic [IDX_W-1:0] wr_data;
  logic [IDX_W-1:0] rd_addr;
  logic [IDX_W-1:0] rd_data;

  logic [IDX_W-1:0] node_sel;
  logic             in_err;
  logic             out_free;

  ufef_ram #(
    .DEPTH (MAX_NODES),
    .W     (IDX_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= ufef_pkg::NODE_COUNT_RESET;
    end else if (cfg_valid) begin
      node_count <= cfg_data;
    end
  end

  // endpoint check against min(node_count, MAX_NODES)
  assign in_err = !(CMP_W'(in_item.first_node) < CMP_W'(node_count)
                    && CMP_W'(in_item.first_node) < MAX_CMP)
               || !(CMP_W'(in_item.second_node) < CMP_W'(node_count)
                    && CMP_W'(in_item.second_node) < MAX_CMP);

  assign node_sel = phase ? IDX_W'(item.second_node) : IDX_W'(item.first_node);
  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == ufef_pkg::S_IDLE);

  always_comb begin
    state_next  = state;
    item_next   = item;
    err_next    = err;
    phase_next  = phase;
    cur_next    = cur;
    root_next   = root;
    root_a_next = root_a;
    clr_next    = clr;
    wr_en       = 1'b0;
    wr_addr     = cur;
    wr_data     = root;
    rd_addr     = cur;
    out_load    = 1'b0;
    out_next.joined      = !err && (root_a != root);
    out_next.index_error = err;
    out_next.edge_first  = item.first_node;
    out_next.edge_second = item.second_node;

    unique case (state)
      ufef_pkg::S_CLEAR: begin
        wr_en    = 1'b1;
        wr_addr  = clr;
        wr_data  = clr;
        clr_next = clr + 1'b1;
        if (clr == LAST_IDX) begin
          state_next = ufef_pkg::S_IDLE;
        end
      end
      ufef_pkg::S_IDLE: begin
        if (in_valid) begin
          item_next  = in_item;
          err_next   = in_err;
          phase_next = 1'b0;
          state_next = in_err ? ufef_pkg::S_DONE : ufef_pkg::S_FIND_ISSUE;
        end
      end
      ufef_pkg::S_FIND_ISSUE: begin
        rd_addr    = node_sel;
        cur_next   = node_sel;
        state_next = ufef_pkg::S_FIND;
      end
      ufef_pkg::S_FIND: begin
        // rd_data holds the parent of cur
        if (rd_data == cur) begin
          root_next  = cur;
          state_next = ufef_pkg::S_COMP_ISSUE;
        end else begin
          cur_next = rd_data;
          rd_addr  = rd_data;
        end
      end
      ufef_pkg::S_COMP_ISSUE: begin
        if (node_sel == root) begin
          if (phase) begin
            state_next = ufef_pkg::S_LINK;
          end else begin
            root_a_next = root;
            phase_next  = 1'b1;
            state_next  = ufef_pkg::S_FIND_ISSUE;
          end
        end else begin
          rd_addr    = node_sel;
          cur_next   = node_sel;
          state_next = ufef_pkg::S_COMP;
        end
      end
      ufef_pkg::S_COMP: begin
        // point cur at the root and step to its old parent
        wr_en   = 1'b1;
        wr_addr = cur;
        wr_data = root;
        if (rd_data == root) begin
          if (phase) begin
            state_next = ufef_pkg::S_LINK;
          end else begin
            root_a_next = root;
            phase_next  = 1'b1;
            state_next  = ufef_pkg::S_FIND_ISSUE;
          end
        end else begin
          cur_next = rd_data;
          rd_addr  = rd_data;
        end
      end
      ufef_pkg::S_LINK: begin
        wr_en      = (root_a != root);
        wr_addr    = root_a;
        wr_data    = root;
        state_next = ufef_pkg::S_DONE;
      end
      ufef_pkg::S_DONE: begin
        if (out_free) begin
          out_load   = 1'b1;
          state_next = ufef_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = ufef_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ufef_pkg::S_CLEAR;
      clr   <= '0;
    end else begin
      state <= state_next;
      clr   <= clr_next;
    end
  end

  always_ff @(posedge clk) begin
    item   <= item_next;
    err    <= err_next;
    phase  <= phase_next;
    cur    <= cur_next;
    root   <= root_next;
    root_a <= root_a_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_item <= out_next;
    end
  end

  // a result never claims both a merge and a bad index
  a_join_err: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_item.joined && out_item.index_error))
    else $error("joined and index_error both set");

  // no edge is taken during the table sweep
  a_clear_block: assert property (@(posedge clk) disable iff (rst)
    state == ufef_pkg::S_CLEAR |-> !in_ready)
    else $error("input ready during table sweep");

  // compression never rewrites the root itself
  a_comp_root: assert property (@(posedge clk) disable iff (rst)
    state == ufef_pkg::S_COMP |-> cur != root)
    else $error("compression write to root");

  // an accepted edge starts work at once
  a_start: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> state != ufef_pkg::S_IDLE)
    else $error("accepted edge left idle");

  // a result load never overwrites one still waiting
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    out_load |-> (!out_valid || out_ready))
    else $error("output register overrun");

endmodule

>>> hdl/ufef_ram.sv
// single write port, single read port parent memory with registered read data
module ufef_ram #(
  parameter int DEPTH = 4096,
  parameter int W     = 12
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [W-1:0]             wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [W-1:0]             rd_data
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

>>> bench/tb_top.sv
// self-checking bench for the union-find edge filter: directed edges, then random phases
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_NODES   = 4096;
  localparam int PERIOD      = 8;
  localparam int QUIET_LIMIT = 40000;
  localparam int N_DIRECTED  = 26;
  localparam int N_PHASES    = 10;

  typedef enum bit {ROW_EDGE, ROW_COUNT} row_kind_t;
  typedef enum bit {BY_MODEL, TYPED} row_check_t;

  typedef struct packed {
    row_kind_t                   kind;
    logic [ufef_pkg::CFG_W-1:0]  count;
    logic [ufef_pkg::NODE_W-1:0] a;
    logic [ufef_pkg::NODE_W-1:0] b;
    row_check_t                  check;
    bit                          joined;
    bit                          err;
  } row_t;

  logic           clk       = 1'b0;
  logic           rst       = 1'b1;
  logic           in_valid  = 1'b0;
  logic           in_ready;
  ufef_pkg::in_t  in_item   = '0;
  logic           out_valid;
  logic           out_ready = 1'b0;
  ufef_pkg::out_t out_item;
  logic           cfg_valid = 1'b0;
  logic           cfg_ready;
  logic [ufef_pkg::CFG_W-1:0] cfg_data = '0;

  // software copy of the disjoint-set forest and the node count
  logic [ufef_pkg::NODE_W-1:0] parent_of [MAX_NODES];
  logic [ufef_pkg::CFG_W-1:0]  count_model;
  ufef_pkg::out_t              verdicts_due [$];
  int                          failures     = 0;
  int                          quiet_cycles = 0;
  int                          burst_left   = 0;

  logic [7:0] ready_mask  = 8'hFF;
  logic [2:0] ready_phase = '0;
  int         ready_span  = 0;

  row_t directed_rows [N_DIRECTED] = '{
    '{ROW_EDGE,  13'd0,    12'd0,    12'd0,    TYPED,    1'b0, 1'b0},
    '{ROW_EDGE,  13'd0,    12'd4095, 12'd4095, TYPED,    1'b0, 1'b0},
    '{ROW_EDGE,  13'd0,    12'd0,    12'd4095, TYPED,    1'b1, 1'b0},
    '{ROW_EDGE,  13'd0,    12'd4095, 12'd0,    TYPED,    1'b0, 1'b0},
    '{ROW_EDGE,  13'd0,    12'd1,    12'd2,    TYPED,    1'b1, 1'b0},
    '{ROW_EDGE,  13'd0,    12'd2,    12'd3,    BY_MODEL, 1'b0, 1'b0},
    '{ROW_EDGE,  13'd0,    12'd3,    12'd1,    BY_MODEL, 1'b0, 1'b0},
    '{ROW_EDGE,  13'd0,    12'd10,   12'd11,   BY_MODEL, 1'b0, 1'b0},
    '{ROW_EDGE,  13'd0,    12'd11,   12'd12,   BY_MODEL, 1'b0, 1'b0},
    '{ROW_EDGE,  13'd0,    12'd12,   12'd13,   BY_MODEL, 1'b0, 1'b0},
    '{ROW_EDGE,  13'd0,    12'd10,   12'd13,   BY_MODEL, 1'b0, 1'b0},
    '{ROW_EDGE,  13'd0,    12'd10,   12'd1,    BY_MODEL, 1'b0, 1'b0},
    '{ROW_EDGE,  13'd0,    12'd2730, 12'd1365, TYPED,    1'b1, 1'b0},
    '{ROW_COUNT, 13'd100,  12'd0,    12'd0,    BY_MODEL, 1'b0, 1'b0},
    '{ROW_EDGE,  13'd0,    12'd100,  12'd0,    TYPED,    1'b0, 1'b1},
    '{ROW_EDGE,  13'd0,    12'd0,    12'd100,  TYPED,    1'b0, 1'b1},
    '{ROW_EDGE,  13'd0,    12'd4095, 12'd99,   TYPED,    1'b0, 1'b1},
    '{ROW_EDGE,  13'd0,    12'd99,   12'd99,   TYPED,    1'b0, 1'b0},
    '{ROW_EDGE,  13'd0,    12'd99,   12'd0,    BY_MODEL, 1'b0, 1'b0},
    '{ROW_COUNT, 13'd0,    12'd0,    12'd0,    BY_MODEL, 1'b0, 1'b0},
    '{ROW_EDGE,  13'd0,    12'd0,    12'd0,    TYPED,    1'b0, 1'b1},
    '{ROW_COUNT, 13'd8191, 12'd0,    12'd0,    BY_MODEL, 1'b0, 1'b0},
    '{ROW_EDGE,  13'd0,    12'd4095, 12'd4094, BY_MODEL, 1'b0, 1'b0},
    '{ROW_COUNT, 13'd1,    12'd0,    12'd0,    BY_MODEL, 1'b0, 1'b0},
    '{ROW_EDGE,  13'd0,    12'd0,    12'd0,    TYPED,    1'b0, 1'b0},
    '{ROW_EDGE,  13'd0,    12'd0,    12'd1,    TYPED,    1'b0, 1'b1}
  };

  // lowering to 16 after the full-size phase leaves deep roots above the count
  logic [ufef_pkg::CFG_W-1:0] phase_count [N_PHASES] = '{
    13'd16, 13'd4096, 13'd5, 13'd1, 13'd0, 13'd200, 13'd8191, 13'd16, 13'd2048, 13'd4096
  };
  int phase_items [N_PHASES] = '{150, 250, 60, 10, 10, 150, 100, 60, 150, 60};

  union_find_edge_filter #(
    .MAX_NODES (MAX_NODES)
  ) i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #(PERIOD/2) clk = ~clk;

  function automatic logic [ufef_pkg::NODE_W-1:0] find_and_flatten(
    input logic [ufef_pkg::NODE_W-1:0] node);
    logic [ufef_pkg::NODE_W-1:0] root;
    logic [ufef_pkg::NODE_W-1:0] walk;
    logic [ufef_pkg::NODE_W-1:0] nxt;
    root = node;
    while (parent_of[root] != root) root = parent_of[root];
    walk = node;
    while (walk != root) begin
      nxt = parent_of[walk];
      parent_of[walk] = root;
      walk = nxt;
    end
    return root;
  endfunction

  // kruskal acceptance step: one verdict per edge
  function automatic ufef_pkg::out_t judge_edge(input ufef_pkg::in_t e);
    ufef_pkg::out_t              v;
    int unsigned                 lim;
    logic [ufef_pkg::NODE_W-1:0] ra;
    logic [ufef_pkg::NODE_W-1:0] rb;
    lim = (count_model > MAX_NODES) ? MAX_NODES : int'(count_model);
    v.edge_first  = e.first_node;
    v.edge_second = e.second_node;
    v.index_error = (e.first_node >= lim) || (e.second_node >= lim);
    v.joined      = 1'b0;
    if (!v.index_error) begin
      ra = find_and_flatten(e.first_node);
      rb = find_and_flatten(e.second_node);
      if (ra != rb) begin
        parent_of[ra] = rb;
        v.joined = 1'b1;
      end
    end
    return v;
  endfunction

  function automatic ufef_pkg::in_t draw_edge(input int unsigned lim,
                                              input int unsigned wbase,
                                              input int unsigned wsize);
    ufef_pkg::in_t e;
    int unsigned   pick;
    pick = $urandom_range(0, 99);
    if (lim == 0) begin
      e.first_node  = ufef_pkg::NODE_W'($urandom_range(0, MAX_NODES - 1));
      e.second_node = ufef_pkg::NODE_W'($urandom_range(0, MAX_NODES - 1));
    end else if (lim < MAX_NODES && pick < 10) begin
      e.first_node  = ufef_pkg::NODE_W'($urandom_range(lim, MAX_NODES - 1));
      e.second_node = pick[0] ? ufef_pkg::NODE_W'($urandom_range(lim, MAX_NODES - 1))
                              : ufef_pkg::NODE_W'($urandom_range(0, lim - 1));
      if (pick[1]) e = {e.second_node, e.first_node};
    end else if (pick < 15) begin
      e.first_node  = ufef_pkg::NODE_W'($urandom_range(0, lim - 1));
      e.second_node = e.first_node;
    end else if (pick < 60) begin
      // clustered endpoints so sets merge and edges get rejected
      e.first_node  = ufef_pkg::NODE_W'(wbase + $urandom_range(0, wsize - 1));
      e.second_node = ufef_pkg::NODE_W'(wbase + $urandom_range(0, wsize - 1));
    end else begin
      e.first_node  = ufef_pkg::NODE_W'($urandom_range(0, lim - 1));
      e.second_node = ufef_pkg::NODE_W'($urandom_range(0, lim - 1));
    end
    return e;
  endfunction

  task automatic send_edge(input ufef_pkg::in_t e, input row_check_t how,
                           input bit want_joined, input bit want_err);
    ufef_pkg::out_t verdict;
    int             gap;
    if (!in_valid) in_valid <= 1'b1;
    in_item <= e;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    verdict = judge_edge(e);
    if (how == TYPED) begin
      verdict.joined      = want_joined;
      verdict.index_error = want_err;
    end
    verdicts_due.insert(verdicts_due.size(), verdict);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end else begin
      burst_left--;
    end
  endtask

  // the count only changes once every edge in flight has come back
  task automatic set_node_count(input logic [ufef_pkg::CFG_W-1:0] v);
    if (in_valid) in_valid <= 1'b0;
    while (verdicts_due.size() != 0) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid   <= 1'b0;
    count_model = v;
  endtask

  always @(posedge clk) begin
    if (ready_span == 0) begin
      ready_mask <= ($urandom_range(0, 2) == 0) ? 8'hFF : (8'($urandom) | 8'h01);
      ready_span <= $urandom_range(16, 120);
    end else begin
      ready_span <= ready_span - 1;
    end
    out_ready   <= ready_mask[ready_phase];
    ready_phase <= ready_phase + 3'd1;
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (verdicts_due.size() == 0) begin
        $error("result with no edge pending: edge_first %0d edge_second %0d",
               out_item.edge_first, out_item.edge_second);
        failures++;
      end else begin
        if (out_item.joined !== verdicts_due[0].joined) begin
          $error("joined: expected %0d, got %0d", verdicts_due[0].joined, out_item.joined);
          failures++;
        end
        if (out_item.index_error !== verdicts_due[0].index_error) begin
          $error("index_error: expected %0d, got %0d",
                 verdicts_due[0].index_error, out_item.index_error);
          failures++;
        end
        if (out_item.edge_first !== verdicts_due[0].edge_first) begin
          $error("edge_first: expected %0d, got %0d",
                 verdicts_due[0].edge_first, out_item.edge_first);
          failures++;
        end
        if (out_item.edge_second !== verdicts_due[0].edge_second) begin
          $error("edge_second: expected %0d, got %0d",
                 verdicts_due[0].edge_second, out_item.edge_second);
          failures++;
        end
        void'(verdicts_due.pop_front());
      end
    end
  end

  // counts cycles without any transfer; covers the clearing sweep after reset
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int            r;
    int            p;
    int unsigned   lim;
    int unsigned   wsize;
    int unsigned   wbase;
    ufef_pkg::in_t e;
    for (r = 0; r < MAX_NODES; r++) parent_of[r] = ufef_pkg::NODE_W'(r);
    count_model = ufef_pkg::NODE_COUNT_RESET;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    for (r = 0; r < N_DIRECTED; r++) begin
      if (directed_rows[r].kind == ROW_COUNT) begin
        set_node_count(directed_rows[r].count);
      end else begin
        e.first_node  = directed_rows[r].a;
        e.second_node = directed_rows[r].b;
        send_edge(e, directed_rows[r].check, directed_rows[r].joined, directed_rows[r].err);
      end
    end

    for (p = 0; p < N_PHASES; p++) begin
      set_node_count(phase_count[p]);
      lim   = (phase_count[p] > MAX_NODES) ? MAX_NODES : int'(phase_count[p]);
      wsize = (lim > 48) ? 48 : ((lim == 0) ? 1 : lim);
      wbase = (lim > wsize) ? $urandom_range(0, lim - wsize) : 0;
      repeat (phase_items[p]) send_edge(draw_edge(lim, wbase, wsize), BY_MODEL, 1'b0, 1'b0);
    end

    if (in_valid) in_valid <= 1'b0;
    while (verdicts_due.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (failures == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

>>> union_find_edge_filter.f
hdl/ufef_pkg.sv
hdl/ufef_ram.sv
hdl/union_find_edge_filter.sv
bench/tb_top.sv
